>>> rtl/core/mfb_pkg.sv
package mfb_pkg;

  localparam int unsigned VERTICES_DEF = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned VX_W    = 4;
  localparam int unsigned CAP_W   = 16;
  localparam int unsigned RES_W   = 17;
  localparam int unsigned VAL_W   = 20;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [VAL_W-1:0] FLOW_MAX = '1;

  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RUN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  localparam logic REPLY_FLOW = 1'b0;
  localparam logic REPLY_READ = 1'b1;

  // register index, taken from paddr bit 2
  localparam logic REG_SOURCE = 1'b0;
  localparam logic REG_SINK   = 1'b1;

  localparam logic [VX_W-1:0] SOURCE_RST = 4'd1;
  localparam logic [VX_W-1:0] SINK_RST   = 4'd2;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLEAR,
    DP_LOAD,
    DP_READ,
    DP_RUN_INIT,
    DP_BFS_INIT,
    DP_POP,
    DP_SCAN_RD,
    DP_SCAN_CHK,
    DP_WALK_INIT,
    DP_WALK_RD,
    DP_NECK_CHK,
    DP_UPD_WRF,
    DP_UPD_WRR,
    DP_FLOW_ADD,
    DP_OUT_READ,
    DP_OUT_FLOW
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic run_ok;
    logic q_empty;
    logic hit;
    logic v_snk;
    logic v_last;
    logic walk_done;
  } stat_t;

  function automatic logic vertex_ok(logic [VX_W-1:0] v, int unsigned n);
    return (v != '0) && (32'(v) < n);
  endfunction

endpackage

>>> rtl/core/mfb_if.sv
interface mfb_in_if;
  logic                             valid;
  logic                             ready;
  logic [mfb_pkg::KIND_W-1:0]       kind;
  logic [mfb_pkg::VX_W-1:0]         row_vertex;
  logic [mfb_pkg::VX_W-1:0]         col_vertex;
  logic [mfb_pkg::CAP_W-1:0]        capacity;

  modport source(output valid, kind, row_vertex, col_vertex, capacity, input ready);
  modport sink(input valid, kind, row_vertex, col_vertex, capacity, output ready);
endinterface

interface mfb_out_if;
  logic                       valid;
  logic                       ready;
  logic                       reply_kind;
  logic [mfb_pkg::VAL_W-1:0]  value;

  modport source(output valid, reply_kind, value, input ready);
  modport sink(input valid, reply_kind, value, output ready);
endinterface

>>> rtl/core/mfb_datapath.sv
module mfb_datapath #(
  parameter int unsigned VERTICES = mfb_pkg::VERTICES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mfb_pkg::cmd_t                cmd_i,
  output mfb_pkg::stat_t               stat_o,
  input  logic [mfb_pkg::VX_W-1:0]     row_i,
  input  logic [mfb_pkg::VX_W-1:0]     col_i,
  input  logic [mfb_pkg::CAP_W-1:0]    cap_i,
  input  logic [mfb_pkg::VX_W-1:0]     src_i,
  input  logic [mfb_pkg::VX_W-1:0]     snk_i,
  output logic                         reply_kind_o,
  output logic [mfb_pkg::VAL_W-1:0]    value_o
);

  localparam int unsigned VW    = $clog2(VERTICES);
  localparam int unsigned CW    = $clog2(VERTICES + 1);
  localparam int unsigned DEPTH = VERTICES * VERTICES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = mfb_pkg::RES_W;

  function automatic logic [AW-1:0] ent(logic [VW-1:0] r, logic [VW-1:0] c);
    return AW'(r * VERTICES + c);
  endfunction

  logic [RW-1:0]          mem [DEPTH];
  logic [RW-1:0]          rd_q;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   we;
  logic [AW-1:0]          wr_addr;
  logic [RW-1:0]          wr_data;

  logic [VW-1:0]          parent_q [VERTICES];
  logic [VW-1:0]          queue_q  [VERTICES];
  logic [VERTICES-1:0]    visited_q;
  logic [CW-1:0]          head_q, tail_q, steps_q;
  logic [VW-1:0]          u_q, v_q, w_q;
  logic [AW-1:0]          clr_q;
  logic [RW-1:0]          neck_q;
  logic [mfb_pkg::VAL_W-1:0] flow_q, value_q;
  logic                   reply_q;
  logic                   read_ok_q;

  logic [VW-1:0]          src_v, snk_v, pw;
  logic                   row_ok, col_ok, hit;
  logic [mfb_pkg::VAL_W:0] flow_sum;

  assign src_v  = VW'(src_i);
  assign snk_v  = VW'(snk_i);
  assign pw     = parent_q[w_q];
  assign row_ok = mfb_pkg::vertex_ok(row_i, VERTICES);
  assign col_ok = mfb_pkg::vertex_ok(col_i, VERTICES);
  assign hit    = (rd_q != '0) && !visited_q[v_q];
  assign flow_sum = {1'b0, flow_q} + (mfb_pkg::VAL_W + 1)'(neck_q);

  assign stat_o.clr_last  = (clr_q == AW'(DEPTH - 1));
  assign stat_o.run_ok    = mfb_pkg::vertex_ok(src_i, VERTICES)
                            && mfb_pkg::vertex_ok(snk_i, VERTICES) && (src_i != snk_i);
  assign stat_o.q_empty   = (head_q == tail_q);
  assign stat_o.hit       = hit;
  assign stat_o.v_snk     = (v_q == snk_v);
  assign stat_o.v_last    = (v_q == VW'(VERTICES - 1));
  assign stat_o.walk_done = (w_q == src_v) || (steps_q == CW'(VERTICES));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ent(u_q, v_q);
    we      = 1'b0;
    wr_addr = ent(pw, w_q);
    wr_data = '0;
    case (cmd_i.op)
      mfb_pkg::DP_CLEAR: begin
        we      = 1'b1;
        wr_addr = clr_q;
      end
      mfb_pkg::DP_LOAD: begin
        we      = row_ok && col_ok;
        wr_addr = ent(VW'(row_i), VW'(col_i));
        wr_data = RW'(cap_i);
      end
      mfb_pkg::DP_READ: begin
        rd_en   = 1'b1;
        rd_addr = ent(VW'(row_i), VW'(col_i));
      end
      mfb_pkg::DP_SCAN_RD: rd_en = 1'b1;
      mfb_pkg::DP_WALK_RD: begin
        rd_en   = 1'b1;
        rd_addr = ent(pw, w_q);
      end
      mfb_pkg::DP_UPD_WRF: begin
        we      = 1'b1;
        wr_data = rd_q - neck_q;
        rd_en   = 1'b1;
        rd_addr = ent(w_q, pw);
      end
      mfb_pkg::DP_UPD_WRR: begin
        we      = 1'b1;
        wr_addr = ent(w_q, pw);
        wr_data = rd_q + neck_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      steps_q   <= '0;
      u_q       <= '0;
      v_q       <= '0;
      w_q       <= '0;
      visited_q <= '0;
      flow_q    <= '0;
    end else begin
      case (cmd_i.op)
        mfb_pkg::DP_CLEAR:    clr_q <= clr_q + AW'(1);
        mfb_pkg::DP_RUN_INIT: flow_q <= '0;
        mfb_pkg::DP_BFS_INIT: begin
          visited_q <= VERTICES'(1) << src_v;
          head_q    <= '0;
          tail_q    <= CW'(1);
        end
        mfb_pkg::DP_POP: begin
          u_q    <= queue_q[head_q[VW-1:0]];
          head_q <= head_q + CW'(1);
          v_q    <= VW'(1);
        end
        mfb_pkg::DP_SCAN_CHK: begin
          v_q <= v_q + VW'(1);
          if (hit && (v_q == snk_v)) begin
            w_q     <= v_q;
            steps_q <= '0;
          end else if (hit) begin
            visited_q[v_q] <= 1'b1;
            if (tail_q < CW'(VERTICES)) begin
              tail_q <= tail_q + CW'(1);
            end
          end
        end
        mfb_pkg::DP_WALK_INIT: begin
          w_q     <= snk_v;
          steps_q <= '0;
        end
        mfb_pkg::DP_NECK_CHK, mfb_pkg::DP_UPD_WRR: begin
          w_q     <= pw;
          steps_q <= steps_q + CW'(1);
        end
        mfb_pkg::DP_FLOW_ADD: begin
          flow_q <= (flow_sum > {1'b0, mfb_pkg::FLOW_MAX}) ? mfb_pkg::FLOW_MAX
                                                          : flow_sum[mfb_pkg::VAL_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      mfb_pkg::DP_READ:     read_ok_q <= row_ok && col_ok;
      mfb_pkg::DP_BFS_INIT: begin
        queue_q[0] <= src_v;
        neck_q     <= '1;
      end
      mfb_pkg::DP_SCAN_CHK: begin
        if (hit) begin
          parent_q[v_q] <= u_q;
          if ((v_q != snk_v) && (tail_q < CW'(VERTICES))) begin
            queue_q[tail_q[VW-1:0]] <= v_q;
          end
        end
      end
      mfb_pkg::DP_NECK_CHK: begin
        if (rd_q < neck_q) begin
          neck_q <= rd_q;
        end
      end
      mfb_pkg::DP_OUT_READ: begin
        reply_q <= mfb_pkg::REPLY_READ;
        value_q <= read_ok_q ? mfb_pkg::VAL_W'(rd_q) : '0;
      end
      mfb_pkg::DP_OUT_FLOW: begin
        reply_q <= mfb_pkg::REPLY_FLOW;
        value_q <= flow_q;
      end
      default: ;
    endcase
  end

  assign reply_kind_o = reply_q;
  assign value_o      = value_q;

endmodule

>>> rtl/core/mfb_ctrl.sv
module mfb_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [mfb_pkg::KIND_W-1:0]    in_kind_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  mfb_pkg::stat_t                stat_i,
  output mfb_pkg::cmd_t                 cmd_o
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_READ_OUT = 4'd2;
  localparam logic [3:0] S_RUN      = 4'd3;
  localparam logic [3:0] S_POP      = 4'd4;
  localparam logic [3:0] S_SCAN_RD  = 4'd5;
  localparam logic [3:0] S_SCAN_CHK = 4'd6;
  localparam logic [3:0] S_NECK_RD  = 4'd7;
  localparam logic [3:0] S_NECK_CHK = 4'd8;
  localparam logic [3:0] S_UPD_RDF  = 4'd9;
  localparam logic [3:0] S_UPD_WRF  = 4'd10;
  localparam logic [3:0] S_UPD_WRR  = 4'd11;
  localparam logic [3:0] S_FLOW_ADD = 4'd12;
  localparam logic [3:0] S_RUN_OUT  = 4'd13;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free, accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = mfb_pkg::DP_NOP;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = mfb_pkg::DP_CLEAR;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_kind_i)
            mfb_pkg::KIND_LOAD: cmd_o.op = mfb_pkg::DP_LOAD;
            mfb_pkg::KIND_READ: begin
              cmd_o.op = mfb_pkg::DP_READ;
              state_d  = S_READ_OUT;
            end
            mfb_pkg::KIND_RUN: begin
              cmd_o.op = mfb_pkg::DP_RUN_INIT;
              state_d  = stat_i.run_ok ? S_RUN : S_RUN_OUT;
            end
            default: ;
          endcase
        end
      end
      S_READ_OUT: begin
        if (out_free) begin
          cmd_o.op    = mfb_pkg::DP_OUT_READ;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_RUN: begin
        cmd_o.op = mfb_pkg::DP_BFS_INIT;
        state_d  = S_POP;
      end
      S_POP: begin
        if (stat_i.q_empty) begin
          state_d = S_RUN_OUT;
        end else begin
          cmd_o.op = mfb_pkg::DP_POP;
          state_d  = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd_o.op = mfb_pkg::DP_SCAN_RD;
        state_d  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd_o.op = mfb_pkg::DP_SCAN_CHK;
        if (stat_i.hit && stat_i.v_snk) begin
          state_d = S_NECK_RD;
        end else if (stat_i.v_last) begin
          state_d = S_POP;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_NECK_RD: begin
        if (stat_i.walk_done) begin
          // restart the walk for the update pass
          cmd_o.op = mfb_pkg::DP_WALK_INIT;
          state_d  = S_UPD_RDF;
        end else begin
          cmd_o.op = mfb_pkg::DP_WALK_RD;
          state_d  = S_NECK_CHK;
        end
      end
      S_NECK_CHK: begin
        cmd_o.op = mfb_pkg::DP_NECK_CHK;
        state_d  = S_NECK_RD;
      end
      S_UPD_RDF: begin
        if (stat_i.walk_done) begin
          state_d = S_FLOW_ADD;
        end else begin
          cmd_o.op = mfb_pkg::DP_WALK_RD;
          state_d  = S_UPD_WRF;
        end
      end
      S_UPD_WRF: begin
        cmd_o.op = mfb_pkg::DP_UPD_WRF;
        state_d  = S_UPD_WRR;
      end
      S_UPD_WRR: begin
        cmd_o.op = mfb_pkg::DP_UPD_WRR;
        state_d  = S_UPD_RDF;
      end
      S_FLOW_ADD: begin
        cmd_o.op = mfb_pkg::DP_FLOW_ADD;
        state_d  = S_RUN;
      end
      S_RUN_OUT: begin
        if (out_free) begin
          cmd_o.op    = mfb_pkg::DP_OUT_FLOW;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |->
      (cmd_o.op != mfb_pkg::DP_OUT_READ && cmd_o.op != mfb_pkg::DP_OUT_FLOW))
    else $error("result register overwritten while stalled");

  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(out_ready_i))
    else $error("result dropped without handshake");

  a_read_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_kind_i == mfb_pkg::KIND_READ) |=> (state_q == S_READ_OUT))
    else $error("read item did not go to reply");
`endif

endmodule

>>> rtl/core/max_flow_bfs_augment.sv
// Edmonds-Karp maximum flow engine over a VERTICES x VERTICES residual matrix.
// in_i carries items: kind 0 loads one capacity entry, kind 1 runs max flow
// between the source and sink registers, kind 2 reads one residual entry.
// out_o carries one reply per run (reply_kind 0, total flow) or read
// (reply_kind 1, residual value). The APB port sets source (0x0) and sink (0x4).
// After reset the matrix is cleared one entry per cycle, VERTICES*VERTICES
// entries (256 by default), with in_i.ready low; configuration is taken then.
// A load leaves in_i ready for the next item. A read registers its entry,
// which moves to the output register once that is free. A run is one search
// per augmenting path: each popped vertex has its row scanned entry by entry,
// a read and a check (the matrix has a single read port); each path
// is walked for its bottleneck, then to update forward and reverse entries.
// One item is in work at a time; ready stays low until a read or run has
// placed its reply in the output register. A stalled receiver holds that
// register; loads are still accepted meanwhile, and the next reply waits.
module max_flow_bfs_augment #(
  parameter int unsigned VERTICES = mfb_pkg::VERTICES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mfb_in_if.sink                         in_i,
  mfb_out_if.source                      out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mfb_pkg::PADDR_W-1:0]    paddr,
  input  logic [mfb_pkg::PDATA_W-1:0]    pwdata,
  output logic [mfb_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);

  logic [mfb_pkg::VX_W-1:0] src_q, snk_q;
  mfb_pkg::cmd_t  cmd;
  mfb_pkg::stat_t stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mfb_pkg::REG_SINK) ? mfb_pkg::PDATA_W'(snk_q)
                                                 : mfb_pkg::PDATA_W'(src_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= mfb_pkg::SOURCE_RST;
      snk_q <= mfb_pkg::SINK_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == mfb_pkg::REG_SOURCE) begin
        src_q <= pwdata[mfb_pkg::VX_W-1:0];
      end else begin
        snk_q <= pwdata[mfb_pkg::VX_W-1:0];
      end
    end
  end

  mfb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mfb_datapath #(
    .VERTICES(VERTICES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .row_i        (in_i.row_vertex),
    .col_i        (in_i.col_vertex),
    .cap_i        (in_i.capacity),
    .src_i        (src_q),
    .snk_i        (snk_q),
    .reply_kind_o (out_o.reply_kind),
    .value_o      (out_o.value)
  );

endmodule

>>> sim/max_flow_bfs_augment_tb.sv
module max_flow_bfs_augment_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NV = mfb_pkg::VERTICES_DEF;
  localparam logic [mfb_pkg::KIND_W-1:0] KIND_BAD = 2'd3;

  typedef struct packed {
    logic                      reply_kind;
    logic [mfb_pkg::VAL_W-1:0] value;
  } reply_t;

  // Predicts replies of the flow engine and checks them in order.
  class flow_scoreboard;
    logic [mfb_pkg::RES_W-1:0] resid [NV*NV];
    logic [mfb_pkg::VX_W-1:0]  src_vx;
    logic [mfb_pkg::VX_W-1:0]  snk_vx;
    reply_t                    pending [$];
    int                        fails;

    function void reset_state();
      foreach (resid[i]) resid[i] = '0;
      src_vx = mfb_pkg::SOURCE_RST;
      snk_vx = mfb_pkg::SINK_RST;
      pending.delete();
      fails = 0;
    endfunction

    function bit vx_good(logic [mfb_pkg::VX_W-1:0] v);
      return v != '0 && int'(v) < NV;
    endfunction

    function bit find_path(ref int par [NV]);
      int q [NV];
      bit seen [NV];
      int head, tail, u;
      head = 0;
      tail = 0;
      foreach (seen[i]) seen[i] = 0;
      q[tail++] = src_vx;
      seen[src_vx] = 1;
      while (head < tail) begin
        u = q[head++];
        for (int v = 1; v < NV; v++) begin
          if (!seen[v] && resid[u*NV+v] != '0) begin
            par[v] = u;
            if (v == snk_vx) return 1;
            if (tail < NV) q[tail++] = v;
            seen[v] = 1;
          end
        end
      end
      return 0;
    endfunction

    function logic [mfb_pkg::VAL_W-1:0] predict_flow();
      int par [NV];
      logic [31:0] neck, total;
      int v, u, steps;
      total = 0;
      foreach (par[i]) par[i] = 0;
      if (!vx_good(src_vx) || !vx_good(snk_vx) || src_vx == snk_vx) return '0;
      while (find_path(par)) begin
        neck = '1;
        v = snk_vx;
        for (steps = 0; v != src_vx && steps < NV; steps++) begin
          u = par[v] % NV;
          if (32'(resid[u*NV+v]) < neck) neck = 32'(resid[u*NV+v]);
          v = u;
        end
        v = snk_vx;
        for (steps = 0; v != src_vx && steps < NV; steps++) begin
          u = par[v] % NV;
          resid[u*NV+v] = resid[u*NV+v] - mfb_pkg::RES_W'(neck);
          resid[v*NV+u] = resid[v*NV+u] + mfb_pkg::RES_W'(neck);
          v = u;
        end
        if (total + neck > 32'(mfb_pkg::FLOW_MAX) || neck > 32'(mfb_pkg::FLOW_MAX))
          total = 32'(mfb_pkg::FLOW_MAX);
        else total = total + neck;
      end
      return total[mfb_pkg::VAL_W-1:0];
    endfunction

    function void note_item(logic [mfb_pkg::KIND_W-1:0] k, logic [mfb_pkg::VX_W-1:0] r,
                            logic [mfb_pkg::VX_W-1:0] c, logic [mfb_pkg::CAP_W-1:0] cap);
      reply_t rp;
      if (k == mfb_pkg::KIND_LOAD) begin
        if (vx_good(r) && vx_good(c)) resid[r*NV+c] = mfb_pkg::RES_W'(cap);
      end else if (k == mfb_pkg::KIND_RUN) begin
        rp.reply_kind = mfb_pkg::REPLY_FLOW;
        rp.value = predict_flow();
        pending.push_back(rp);
      end else if (k == mfb_pkg::KIND_READ) begin
        rp.reply_kind = mfb_pkg::REPLY_READ;
        rp.value = (vx_good(r) && vx_good(c)) ? mfb_pkg::VAL_W'(resid[r*NV+c]) : '0;
        pending.push_back(rp);
      end
    endfunction

    function void check_reply(logic rk, logic [mfb_pkg::VAL_W-1:0] val);
      reply_t want;
      if (pending.size() == 0) begin
        $error("unexpected reply kind %0d value %0d", rk, val);
        fails++;
        return;
      end
      want = pending.pop_front();
      if (rk !== want.reply_kind) begin
        $error("reply_kind expected %0d actual %0d", want.reply_kind, rk);
        fails++;
      end
      if (val !== want.value) begin
        $error("value expected %0d actual %0d", want.value, val);
        fails++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [mfb_pkg::PADDR_W-1:0] paddr = '0;
  logic [mfb_pkg::PDATA_W-1:0] pwdata = '0;
  logic [mfb_pkg::PDATA_W-1:0] prdata;
  logic pready;

  mfb_in_if  in_ch ();
  mfb_out_if out_ch ();

  max_flow_bfs_augment dut (
    .clk_i, .rst_ni, .in_i(in_ch.sink), .out_o(out_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  flow_scoreboard sb;
  bit idle_ok = 1;
  bit hold_off = 0;
  bit sink_busy = 1;
  int n_sent = 0;

  always #4 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 0;
    in_ch.kind = '0;
    in_ch.row_vertex = '0;
    in_ch.col_vertex = '0;
    in_ch.capacity = '0;
    out_ch.ready = 0;
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_off) out_ch.ready <= 0;
    else if (idle_ok && sink_busy) out_ch.ready <= ($urandom_range(99) >= 30);
    else out_ch.ready <= 1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_reply(out_ch.reply_kind, out_ch.value);
  end

  task automatic reg_write(logic idx, logic [mfb_pkg::VX_W-1:0] val);
    @(negedge clk_i);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= mfb_pkg::PDATA_W'(val);
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (idx == mfb_pkg::REG_SOURCE) sb.src_vx = val;
    else sb.snk_vx = val;
  endtask

  // Offer one item at the falling edge; keep valid high into the next item.
  task automatic send_item(logic [mfb_pkg::KIND_W-1:0] k, logic [mfb_pkg::VX_W-1:0] r,
                           logic [mfb_pkg::VX_W-1:0] c, logic [mfb_pkg::CAP_W-1:0] cap);
    @(negedge clk_i);
    while (idle_ok && $urandom_range(99) < 30) begin
      in_ch.valid <= 0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1;
    in_ch.kind <= k;
    in_ch.row_vertex <= r;
    in_ch.col_vertex <= c;
    in_ch.capacity <= cap;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_item(k, r, c, cap);
    n_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_ch.valid <= 0;
  endtask

  task automatic drain();
    stop_sending();
    while (sb.pending.size() != 0) @(posedge clk_i);
    // allow an in-flight load to settle
    repeat (20) @(posedge clk_i);
  endtask

  task automatic rand_edge(int nv);
    logic [mfb_pkg::CAP_W-1:0] cap;
    case ($urandom_range(3))
      0: cap = mfb_pkg::CAP_W'($urandom_range(9));
      1: cap = '1;
      default: cap = mfb_pkg::CAP_W'($urandom);
    endcase
    send_item(mfb_pkg::KIND_LOAD, mfb_pkg::VX_W'($urandom_range(1, nv)),
              mfb_pkg::VX_W'($urandom_range(1, nv)), cap);
  endtask

  // Build a small graph, run it, read some residuals, clear it.
  task automatic graph_round(int nv);
    int edges;
    edges = $urandom_range(2, 3 * nv);
    for (int i = 0; i < edges; i++) rand_edge(nv);
    send_item(mfb_pkg::KIND_RUN, mfb_pkg::VX_W'($urandom), mfb_pkg::VX_W'($urandom),
              mfb_pkg::CAP_W'($urandom));
    for (int i = 0; i < 3; i++)
      send_item(mfb_pkg::KIND_READ, mfb_pkg::VX_W'($urandom_range(1, nv)),
                mfb_pkg::VX_W'($urandom_range(1, nv)), mfb_pkg::CAP_W'($urandom));
    if ($urandom_range(9) == 0)
      send_item(mfb_pkg::KIND_RUN, mfb_pkg::VX_W'($urandom), mfb_pkg::VX_W'($urandom),
                mfb_pkg::CAP_W'($urandom));
    if ($urandom_range(3) == 0) begin
      // noise: bad vertices, unknown kind
      send_item(mfb_pkg::KIND_W'($urandom), mfb_pkg::VX_W'($urandom),
                mfb_pkg::VX_W'($urandom), mfb_pkg::CAP_W'($urandom));
      send_item(KIND_BAD, mfb_pkg::VX_W'($urandom), mfb_pkg::VX_W'($urandom),
                mfb_pkg::CAP_W'($urandom));
    end
    for (int r = 1; r <= nv; r++)
      for (int c = 1; c <= nv; c++)
        if (sb.resid[r*NV+c] != '0)
          send_item(mfb_pkg::KIND_LOAD, mfb_pkg::VX_W'(r), mfb_pkg::VX_W'(c), '0);
  endtask

  initial begin
    int nv;
    sb = new();
    sb.reset_state();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed
    send_item(mfb_pkg::KIND_READ, 4'd1, 4'd2, '0);
    send_item(mfb_pkg::KIND_RUN, 4'd0, 4'd0, '0);
    send_item(mfb_pkg::KIND_LOAD, 4'd1, 4'd2, 16'hFFFF);
    send_item(mfb_pkg::KIND_LOAD, 4'd0, 4'd2, 16'd5);
    send_item(mfb_pkg::KIND_LOAD, 4'd15, 4'd0, 16'd5);
    send_item(mfb_pkg::KIND_LOAD, 4'd1, 4'd15, 16'hFFFF);
    send_item(mfb_pkg::KIND_LOAD, 4'd15, 4'd2, 16'hFFFF);
    send_item(mfb_pkg::KIND_LOAD, 4'd1, 4'd3, 16'hFFFF);
    send_item(mfb_pkg::KIND_LOAD, 4'd3, 4'd2, 16'hFFFF);
    send_item(KIND_BAD, 4'd1, 4'd2, 16'd7);
    send_item(mfb_pkg::KIND_RUN, 4'd0, 4'd0, '0);
    send_item(mfb_pkg::KIND_READ, 4'd2, 4'd1, '0);
    send_item(mfb_pkg::KIND_READ, 4'd0, 4'd2, '0);
    send_item(mfb_pkg::KIND_READ, 4'd15, 4'd15, '0);
    send_item(mfb_pkg::KIND_RUN, 4'd0, 4'd0, '0);
    drain();
    reg_write(mfb_pkg::REG_SOURCE, 4'd2);
    reg_write(mfb_pkg::REG_SINK, 4'd2);
    send_item(mfb_pkg::KIND_RUN, '0, '0, '0);
    drain();
    reg_write(mfb_pkg::REG_SOURCE, 4'd0);
    reg_write(mfb_pkg::REG_SINK, 4'd15);
    send_item(mfb_pkg::KIND_RUN, '0, '0, '0);
    drain();
    // full edges both ways; a first run doubles the reverse entries, so the
    // run back the other way pushes the total into saturation
    for (int v = 2; v < 15; v++) begin
      send_item(mfb_pkg::KIND_LOAD, 4'd15, mfb_pkg::VX_W'(v), 16'hFFFF);
      send_item(mfb_pkg::KIND_LOAD, mfb_pkg::VX_W'(v), 4'd15, 16'hFFFF);
      send_item(mfb_pkg::KIND_LOAD, mfb_pkg::VX_W'(v), 4'd1, 16'hFFFF);
      send_item(mfb_pkg::KIND_LOAD, 4'd1, mfb_pkg::VX_W'(v), 16'hFFFF);
    end
    send_item(mfb_pkg::KIND_LOAD, 4'd15, 4'd1, 16'hFFFF);
    drain();
    reg_write(mfb_pkg::REG_SOURCE, 4'd1);
    reg_write(mfb_pkg::REG_SINK, 4'd15);
    send_item(mfb_pkg::KIND_RUN, '0, '0, '0);
    drain();
    reg_write(mfb_pkg::REG_SOURCE, 4'd15);
    reg_write(mfb_pkg::REG_SINK, 4'd1);
    send_item(mfb_pkg::KIND_RUN, '0, '0, '0);
    drain();

    // long hold-off on the receiver while items keep coming
    hold_off = 1;
    fork
      begin
        for (int i = 0; i < 8; i++)
          send_item(mfb_pkg::KIND_READ, 4'd1, mfb_pkg::VX_W'(i), '0);
      end
      begin
        repeat (300) @(posedge clk_i);
        @(negedge clk_i);
        hold_off = 0;
      end
    join
    drain();
    for (int r = 1; r < 16; r++)
      for (int c = 1; c < 16; c++)
        if (sb.resid[r*NV+c] != '0)
          send_item(mfb_pkg::KIND_LOAD, mfb_pkg::VX_W'(r), mfb_pkg::VX_W'(c), '0);

    while (n_sent < 1600) begin
      if ($urandom_range(7) == 0) begin
        drain();
        case ($urandom_range(3))
          0: begin
            reg_write(mfb_pkg::REG_SOURCE, 4'd1);
            reg_write(mfb_pkg::REG_SINK, 4'd15);
          end
          1: begin
            reg_write(mfb_pkg::REG_SOURCE, 4'd15);
            reg_write(mfb_pkg::REG_SINK, 4'd1);
          end
          default: begin
            reg_write(mfb_pkg::REG_SOURCE, mfb_pkg::VX_W'($urandom));
            reg_write(mfb_pkg::REG_SINK, mfb_pkg::VX_W'($urandom));
          end
        endcase
      end
      idle_ok = (n_sent < 700 || n_sent > 1000);
      sink_busy = idle_ok;
      nv = ($urandom_range(9) == 0) ? 15 : $urandom_range(3, 6);
      graph_round(nv);
    end
    idle_ok = 1;
    sink_busy = 1;
    drain();
    repeat (50) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #100ms;
    $display("Verification failed");
    $finish;
  end
endmodule
